>>> rtl/gcb_pkg.sv
// shared constants, types and the arctangent table of the bearing pipeline
package gcb_pkg;

   // angle formats and cordic depth
   localparam int ANGLE_FRAC_BITS = 20;
   localparam int CORDIC_STAGES   = 24;
   localparam int INT_FRAC        = 24;
   localparam int SCALE_SHIFT     = INT_FRAC - ANGLE_FRAC_BITS;

   // field and datapath widths
   localparam int ADDR_W  = 24;
   localparam int LAT_W   = 28;
   localparam int LON_W   = 29;
   localparam int ANG_W   = 30;
   localparam int BEAR_W  = 25;
   localparam int SC_W    = 32;
   localparam int PR_W    = 34;
   localparam int XY_W    = 35;
   localparam int RED_W   = 36;
   localparam int M_W     = 34;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from the word address
   localparam logic REG_REF_LATITUDE  = 1'b0;
   localparam logic REG_REF_LONGITUDE = 1'b1;

   // modulo 360 reduction by conditional subtraction of 360 * 2^k
   localparam longint unsigned RED_DIV_L = 64'd360 << ANGLE_FRAC_BITS;
   localparam int RED_STEPS = $clog2((64'd1 << 30) / RED_DIV_L + 64'd1) + 1;
   localparam logic [RED_W-1:0] RED_DIV    = RED_W'(RED_DIV_L);
   localparam logic [RED_W-1:0] RED_OFFSET = RED_W'(RED_DIV_L << (RED_STEPS - 1));

   localparam logic signed [M_W-1:0] DEG360_A = M_W'(64'sd360 <<< ANGLE_FRAC_BITS);
   localparam logic signed [M_W-1:0] DEG180_A = M_W'(64'sd180 <<< ANGLE_FRAC_BITS);
   localparam logic signed [M_W-1:0] DEG90_A  = M_W'(64'sd90 <<< ANGLE_FRAC_BITS);
   localparam logic signed [ANG_W-1:0] WINDOW_A = ANG_W'(64'sd2 <<< ANGLE_FRAC_BITS);

   // fixed-point constants
   localparam logic signed [27:0] DEG_TO_RAD_K    = 28'sd74961321;
   localparam logic signed [23:0] RAD_TO_DEG_K    = 24'sd3754936;
   localparam logic signed [XY_W-1:0] GAIN_INV    = XY_W'(64'sd652032874);
   localparam logic signed [XY_W-1:0] PI_Q30      = XY_W'(64'sd3373259426);
   localparam logic signed [BEAR_W-1:0] BEAR_LIMIT = BEAR_W'(64'sd11796480);

   typedef logic [ADDR_W-1:0] addr_type;

   // control travelling beside each pipeline stage
   typedef struct packed {
      logic     valid;
      addr_type tag;
   } pipe_ctl_type;

   // arctangent of 2^-k, radians with 30 fraction bits
   function automatic logic signed [XY_W-1:0] atan_q30(input int k);
      logic signed [XY_W-1:0] a;
      case (k)
         0:  a = XY_W'(64'h3243F6A8);
         1:  a = XY_W'(64'h1DAC6705);
         2:  a = XY_W'(64'h0FADBAFC);
         3:  a = XY_W'(64'h07F56EA6);
         4:  a = XY_W'(64'h03FEAB76);
         5:  a = XY_W'(64'h01FFD55B);
         6:  a = XY_W'(64'h00FFFAAA);
         7:  a = XY_W'(64'h007FFF55);
         8:  a = XY_W'(64'h003FFFEA);
         9:  a = XY_W'(64'h001FFFFD);
         10: a = XY_W'(64'h000FFFFF);
         11: a = XY_W'(64'h0007FFFF);
         12: a = XY_W'(64'h0003FFFF);
         13: a = XY_W'(64'h0001FFFF);
         14: a = XY_W'(64'h0000FFFF);
         15: a = XY_W'(64'h00007FFF);
         16: a = XY_W'(64'h00003FFF);
         17: a = XY_W'(64'h00001FFF);
         18: a = XY_W'(64'h00000FFF);
         19: a = XY_W'(64'h000007FF);
         20: a = XY_W'(64'h000003FF);
         21: a = XY_W'(64'h000001FF);
         22: a = XY_W'(64'h000000FF);
         23: a = XY_W'(64'h0000007F);
         24: a = XY_W'(64'h0000003F);
         25: a = XY_W'(64'h0000001F);
         26: a = XY_W'(64'h0000000F);
         27: a = XY_W'(64'h00000008);
         28: a = XY_W'(64'h00000004);
         29: a = XY_W'(64'h00000002);
         30: a = XY_W'(64'h00000001);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

>>> rtl/gcb_channels.sv
// valid/ready channel interfaces for reports and bearings
interface gcb_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [gcb_pkg::ADDR_W-1:0]               aircraft_address;
   logic signed [gcb_pkg::LAT_W-1:0]         latitude;
   logic signed [gcb_pkg::LON_W-1:0]         longitude;

   modport source (output valid, aircraft_address, latitude, longitude, input ready);
   modport sink   (input valid, aircraft_address, latitude, longitude, output ready);
endinterface

interface gcb_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [gcb_pkg::ADDR_W-1:0]               result_address;
   logic signed [gcb_pkg::BEAR_W-1:0]        bearing;

   modport source (output valid, result_address, bearing, input ready);
   modport sink   (input valid, result_address, bearing, output ready);
endinterface

>>> rtl/gcb_sincos.sv
// pipelined angle reduction and rotation cordic giving sine and cosine
module gcb_sincos (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  gcb_pkg::pipe_ctl_type               in_ctl,
   input  logic signed [gcb_pkg::ANG_W-1:0]    angle,
   output gcb_pkg::pipe_ctl_type               out_ctl,
   output logic signed [gcb_pkg::SC_W-1:0]     sine,
   output logic signed [gcb_pkg::SC_W-1:0]     cosine
);
   import gcb_pkg::*;

   localparam int PROD_W = M_W + 28;

   // stage 1: reduce to [-180, 180)
   logic [RED_W-1:0]       red_u;
   logic signed [M_W-1:0]  red_in, red_ff;
   pipe_ctl_type           ctl1_ff;

   always_comb begin
      red_u = RED_W'(angle) + RED_OFFSET;
      for (int k = RED_STEPS - 1; k >= 0; k--) begin
         if (red_u >= (RED_DIV << k)) begin
            red_u = red_u - (RED_DIV << k);
         end
      end
      red_in = signed'(M_W'(red_u));
      if (red_in >= DEG180_A) begin
         red_in = red_in - DEG360_A;
      end
   end

   // stage 2: fold into [-90, 90] and scale to radians
   logic signed [M_W-1:0]    fold_m, scaled;
   logic                     flip_in, flip2_ff;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   pipe_ctl_type             ctl2_ff;

   always_comb begin
      fold_m  = red_ff;
      flip_in = 1'b0;
      if (red_ff > DEG90_A) begin
         fold_m  = red_ff - DEG180_A;
         flip_in = 1'b1;
      end else if (red_ff < -DEG90_A) begin
         fold_m  = red_ff + DEG180_A;
         flip_in = 1'b1;
      end
      scaled  = fold_m <<< SCALE_SHIFT;
      prod_in = scaled * DEG_TO_RAD_K;
   end

   // stage 3 feeds the rotation chain
   logic signed [XY_W-1:0] rx_ff [CORDIC_STAGES+1];
   logic signed [XY_W-1:0] ry_ff [CORDIC_STAGES+1];
   logic signed [XY_W-1:0] rz_ff [CORDIC_STAGES+1];
   logic                   rflip_ff [CORDIC_STAGES+1];
   pipe_ctl_type           rctl_ff [CORDIC_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid    <= 1'b0;
         ctl2_ff.valid    <= 1'b0;
         rctl_ff[0].valid <= 1'b0;
      end else if (enable) begin
         ctl1_ff    <= in_ctl;
         red_ff     <= red_in;
         ctl2_ff    <= ctl1_ff;
         flip2_ff   <= flip_in;
         prod_ff    <= prod_in;
         rctl_ff[0] <= ctl2_ff;
         rflip_ff[0] <= flip2_ff;
         rx_ff[0]   <= GAIN_INV;
         ry_ff[0]   <= '0;
         rz_ff[0]   <= XY_W'(prod_ff >>> 26);
      end
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      logic signed [XY_W-1:0] x_in, y_in, z_in;

      always_comb begin
         if (rz_ff[i] >= 0) begin
            x_in = rx_ff[i] - (ry_ff[i] >>> (i % 32));
            y_in = ry_ff[i] + (rx_ff[i] >>> (i % 32));
            z_in = rz_ff[i] - atan_q30(i % 32);
         end else begin
            x_in = rx_ff[i] + (ry_ff[i] >>> (i % 32));
            y_in = ry_ff[i] - (rx_ff[i] >>> (i % 32));
            z_in = rz_ff[i] + atan_q30(i % 32);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rctl_ff[i+1].valid <= 1'b0;
         end else if (enable) begin
            rctl_ff[i+1]  <= rctl_ff[i];
            rflip_ff[i+1] <= rflip_ff[i];
            rx_ff[i+1]    <= x_in;
            ry_ff[i+1]    <= y_in;
            rz_ff[i+1]    <= z_in;
         end
      end
   end

   // undo the half-turn fold
   assign out_ctl = rctl_ff[CORDIC_STAGES];
   assign cosine  = rflip_ff[CORDIC_STAGES] ? SC_W'(-rx_ff[CORDIC_STAGES])
                                            : SC_W'(rx_ff[CORDIC_STAGES]);
   assign sine    = rflip_ff[CORDIC_STAGES] ? SC_W'(-ry_ff[CORDIC_STAGES])
                                            : SC_W'(ry_ff[CORDIC_STAGES]);

endmodule

>>> rtl/gcb_atan2.sv
// pipelined vectoring cordic giving the bearing in degrees
module gcb_atan2 (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  gcb_pkg::pipe_ctl_type               in_ctl,
   input  logic signed [gcb_pkg::XY_W-1:0]     y_val,
   input  logic signed [gcb_pkg::XY_W-1:0]     x_val,
   output gcb_pkg::pipe_ctl_type               out_ctl,
   output logic signed [gcb_pkg::BEAR_W-1:0]   bearing
);
   import gcb_pkg::*;

   localparam int PROD_W = XY_W + 24;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< 29);

   logic signed [XY_W-1:0] vx_ff [CORDIC_STAGES+1];
   logic signed [XY_W-1:0] vy_ff [CORDIC_STAGES+1];
   logic signed [XY_W-1:0] vz_ff [CORDIC_STAGES+1];
   logic                   vzero_ff [CORDIC_STAGES+1];
   pipe_ctl_type           vctl_ff [CORDIC_STAGES+1];

   // move the vector into the right half plane
   logic signed [XY_W-1:0] x0_in, y0_in, z0_in;
   logic                   zero_in;

   always_comb begin
      zero_in = (x_val == 0) && (y_val == 0);
      x0_in   = x_val;
      y0_in   = y_val;
      z0_in   = '0;
      if (x_val < 0) begin
         z0_in = (y_val >= 0) ? PI_Q30 : -PI_Q30;
         x0_in = -x_val;
         y0_in = -y_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vctl_ff[0].valid <= 1'b0;
      end else if (enable) begin
         vctl_ff[0]  <= in_ctl;
         vzero_ff[0] <= zero_in;
         vx_ff[0]    <= x0_in;
         vy_ff[0]    <= y0_in;
         vz_ff[0]    <= z0_in;
      end
   end

   // one micro-rotation per stage, driving y towards zero
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
      logic signed [XY_W-1:0] x_in, y_in, z_in;

      always_comb begin
         if (vy_ff[i] < 0) begin
            x_in = vx_ff[i] - (vy_ff[i] >>> (i % 32));
            y_in = vy_ff[i] + (vx_ff[i] >>> (i % 32));
            z_in = vz_ff[i] - atan_q30(i % 32);
         end else begin
            x_in = vx_ff[i] + (vy_ff[i] >>> (i % 32));
            y_in = vy_ff[i] - (vx_ff[i] >>> (i % 32));
            z_in = vz_ff[i] + atan_q30(i % 32);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vctl_ff[i+1].valid <= 1'b0;
         end else if (enable) begin
            vctl_ff[i+1]  <= vctl_ff[i];
            vzero_ff[i+1] <= vzero_ff[i];
            vx_ff[i+1]    <= x_in;
            vy_ff[i+1]    <= y_in;
            vz_ff[i+1]    <= z_in;
         end
      end
   end

   // radians to degrees product
   logic signed [PROD_W-1:0] deg_ff;
   logic                     dzero_ff;
   pipe_ctl_type             dctl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dctl_ff.valid <= 1'b0;
      end else if (enable) begin
         dctl_ff  <= vctl_ff[CORDIC_STAGES];
         dzero_ff <= vzero_ff[CORDIC_STAGES];
         deg_ff   <= vz_ff[CORDIC_STAGES] * RAD_TO_DEG_K;
      end
   end

   // round, saturate, zero vector gives zero
   logic signed [PROD_W-1:0] deg_round;

   always_comb begin
      deg_round = (deg_ff + ROUND_HALF) >>> 30;
      if (dzero_ff) begin
         bearing = '0;
      end else if (deg_round > BEAR_LIMIT) begin
         bearing = BEAR_LIMIT;
      end else if (deg_round < -BEAR_LIMIT) begin
         bearing = -BEAR_LIMIT;
      end else begin
         bearing = BEAR_W'(deg_round);
      end
   end

   assign out_ctl = dctl_ff;

endmodule

>>> rtl/gated_great_circle_bearing.sv
// top level: position gate, trigonometry pipelines, combining products and output register
//
// Reports enter on req_chan (address, latitude, longitude in degrees with
// ANGLE_FRAC_BITS fraction bits). Reports outside a +/-2 degree window
// around the reference point are dropped and give no transfer on rsp_chan;
// the others give one transfer carrying the address and the initial bearing
// from the reference, degrees with 16 fraction bits.
// The reference point is set through the csr_ port: ref_latitude at byte
// address 0, ref_longitude at 4. Write it only while the pipeline is empty.
// The pipeline has one gate stage, three reduction stages and one stage
// per rotation in the sine and cosine pipelines, three product stages, one
// stage per vectoring rotation plus two in the arctangent, and the output
// register. Throughput is one report per cycle unless rsp_chan stalls; the
// three sine/cosine pipelines and the vectoring pipeline each take a new
// item every cycle.
// When rsp_chan stalls the whole pipeline holds in place and req_chan.ready
// falls, so nothing is lost or repeated. Reset clears all valid bits and
// both reference registers.
module gated_great_circle_bearing (
   input  logic                                  clock,
   input  logic                                  reset,
   gcb_req_if.sink                               req_chan,
   gcb_rsp_if.source                             rsp_chan,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [gcb_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [gcb_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [gcb_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);
   import gcb_pkg::*;

   localparam int MP_W = 2 * SC_W;

   logic enable;

   // reference registers
   logic signed [LAT_W-1:0] ref_lat_ff;
   logic signed [LON_W-1:0] ref_lon_ff;
   logic                    csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_lat_ff <= '0;
         ref_lon_ff <= '0;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_REF_LATITUDE:  ref_lat_ff <= LAT_W'(csr_pwdata);
            REG_REF_LONGITUDE: ref_lon_ff <= LON_W'(csr_pwdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_REF_LATITUDE:  csr_prdata = CSR_DATA_W'(ref_lat_ff);
         REG_REF_LONGITUDE: csr_prdata = CSR_DATA_W'(ref_lon_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // whole pipeline advances unless the output holds a waiting result
   logic                    rsp_valid_ff;
   addr_type                rsp_addr_ff;
   logic signed [BEAR_W-1:0] rsp_bear_ff;

   assign enable         = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = enable;

   // position gate
   logic signed [ANG_W-1:0] lat_w, lon_w, rlat_w, rlon_w;
   logic                    in_window;

   always_comb begin
      lat_w  = ANG_W'(req_chan.latitude);
      lon_w  = ANG_W'(req_chan.longitude);
      rlat_w = ANG_W'(ref_lat_ff);
      rlon_w = ANG_W'(ref_lon_ff);
      in_window = (lat_w >= rlat_w - WINDOW_A) && (lat_w < rlat_w + WINDOW_A) &&
                  (lon_w >= rlon_w - WINDOW_A) && (lon_w < rlon_w + WINDOW_A);
   end

   pipe_ctl_type            s0_ctl_ff;
   logic signed [ANG_W-1:0] s0_lat_ff, s0_ref_ff, s0_dlon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         s0_ctl_ff.valid <= req_chan.valid && in_window;
         s0_ctl_ff.tag   <= req_chan.aircraft_address;
         s0_lat_ff       <= lat_w;
         s0_ref_ff       <= rlat_w;
         s0_dlon_ff      <= lon_w - rlon_w;
      end
   end

   // sine and cosine of the three angles
   pipe_ctl_type          sc_ctl, sc_ref_ctl, sc_dl_ctl;
   logic signed [SC_W-1:0] s_lat, c_lat, s_ref, c_ref, s_dl, c_dl;

   gcb_sincos u_sc_lat (
      .clock, .reset, .enable,
      .in_ctl(s0_ctl_ff), .angle(s0_lat_ff),
      .out_ctl(sc_ctl), .sine(s_lat), .cosine(c_lat)
   );

   gcb_sincos u_sc_ref (
      .clock, .reset, .enable,
      .in_ctl(s0_ctl_ff), .angle(s0_ref_ff),
      .out_ctl(sc_ref_ctl), .sine(s_ref), .cosine(c_ref)
   );

   gcb_sincos u_sc_dlon (
      .clock, .reset, .enable,
      .in_ctl(s0_ctl_ff), .angle(s0_dlon_ff),
      .out_ctl(sc_dl_ctl), .sine(s_dl), .cosine(c_dl)
   );

   // first products
   logic signed [MP_W-1:0] prod_y, prod_p, prod_q, prod_r;
   pipe_ctl_type           m1_ctl_ff, m2_ctl_ff, m3_ctl_ff;
   logic signed [PR_W-1:0] m1_y_ff, m1_p_ff, m1_q_ff;
   logic signed [SC_W-1:0] m1_cdl_ff;
   logic signed [PR_W-1:0] m2_y_ff, m2_q_ff, m2_r_ff;
   logic signed [XY_W-1:0] m3_y_ff, m3_x_ff;

   assign prod_y = s_dl * c_lat;
   assign prod_p = s_ref * c_lat;
   assign prod_q = c_ref * s_lat;
   assign prod_r = MP_W'(m1_p_ff) * MP_W'(m1_cdl_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ctl_ff.valid <= 1'b0;
         m2_ctl_ff.valid <= 1'b0;
         m3_ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         m1_ctl_ff <= sc_ctl;
         m1_y_ff   <= PR_W'(prod_y >>> 30);
         m1_p_ff   <= PR_W'(prod_p >>> 30);
         m1_q_ff   <= PR_W'(prod_q >>> 30);
         m1_cdl_ff <= c_dl;
         // second-level product
         m2_ctl_ff <= m1_ctl_ff;
         m2_y_ff   <= m1_y_ff;
         m2_q_ff   <= m1_q_ff;
         m2_r_ff   <= PR_W'(prod_r >>> 30);
         // north component
         m3_ctl_ff <= m2_ctl_ff;
         m3_y_ff   <= XY_W'(m2_y_ff);
         m3_x_ff   <= XY_W'(m2_q_ff) - XY_W'(m2_r_ff);
      end
   end

   // bearing
   pipe_ctl_type             at_ctl;
   logic signed [BEAR_W-1:0] at_bear;

   gcb_atan2 u_atan2 (
      .clock, .reset, .enable,
      .in_ctl(m3_ctl_ff), .y_val(m3_y_ff), .x_val(m3_x_ff),
      .out_ctl(at_ctl), .bearing(at_bear)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= at_ctl.valid;
         rsp_addr_ff  <= at_ctl.tag;
         rsp_bear_ff  <= at_bear;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.result_address = rsp_addr_ff;
   assign rsp_chan.bearing        = rsp_bear_ff;

endmodule

>>> rtl/gcb_checker.sv
// port-level checks on the bearing block, bound to the top level
module gcb_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_ready,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [gcb_pkg::ADDR_W-1:0]        rsp_address,
   input  logic signed [gcb_pkg::BEAR_W-1:0] rsp_bearing
);
   import gcb_pkg::*;

   // a waiting result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled output blocks new reports
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("report taken while output stalled");

   // bearing stays within half a turn
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bearing <= BEAR_LIMIT) && (rsp_bearing >= -BEAR_LIMIT))
      else $error("bearing out of range");

   // reset empties the output
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   // stalled result does not change
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_address) && $stable(rsp_bearing))
      else $error("stalled result changed");

endmodule

bind gated_great_circle_bearing gcb_checker u_gcb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_address (rsp_chan.result_address),
   .rsp_bearing (rsp_chan.bearing)
);

>>> sim/tb_gated_great_circle_bearing.sv
// testbench for the gated great-circle bearing pipeline: reference settings, reports, bearing checks
`timescale 1ns / 100ps

module tb_gated_great_circle_bearing;
   import gcb_pkg::*;

   localparam longint ONE_DEG   = 64'sd1 << ANGLE_FRAC_BITS;
   localparam longint WIN_HALF  = 2 * ONE_DEG;
   localparam longint LAT_MAX   = 90 * ONE_DEG;
   localparam longint LON_MAX   = 180 * ONE_DEG;
   localparam int     PIPE_WAIT = 2 * CORDIC_STAGES + 20;
   localparam logic [CSR_ADDR_W-1:0] LAT_REG_ADDR = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] LON_REG_ADDR = CSR_ADDR_W'(4);

   // arctangent of 2^-k, radians, 30 fraction bits
   localparam longint ARCTAN_Q30 [0:31] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
      64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
      64'h00000001, 64'h00000000};

   typedef struct {
      logic [ADDR_W-1:0]        address;
      logic signed [BEAR_W-1:0] bearing;
   } bearing_result_type;

   // expected bearings in arrival order, with the gate and trigonometry worked out here
   class bearing_scoreboard;
      longint             ref_lat;
      longint             ref_lon;
      bearing_result_type awaited[$];
      int                 failures;
      int                 matched;
      int                 dropped;

      function new();
         ref_lat  = 0;
         ref_lon  = 0;
         failures = 0;
         matched  = 0;
         dropped  = 0;
      endfunction

      function void sine_cosine(input longint angle, output longint s, output longint c);
         longint m, x, y, z, t, xs, ys;
         bit     flip;
         m    = (angle <<< (INT_FRAC - ANGLE_FRAC_BITS)) % (64'sd360 <<< INT_FRAC);
         flip = 0;
         if (m < 0) m += 64'sd360 <<< INT_FRAC;
         if (m >= (64'sd180 <<< INT_FRAC)) m -= 64'sd360 <<< INT_FRAC;
         if (m > (64'sd90 <<< INT_FRAC)) begin
            m -= 64'sd180 <<< INT_FRAC;
            flip = 1;
         end else if (m < -(64'sd90 <<< INT_FRAC)) begin
            m += 64'sd180 <<< INT_FRAC;
            flip = 1;
         end
         z = (m * 64'sd74961321) >>> 26;
         x = 64'sd652032874;
         y = 0;
         for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               t = x - ys; y = y + xs; x = t; z -= ARCTAN_Q30[i];
            end else begin
               t = x + ys; y = y - xs; x = t; z += ARCTAN_Q30[i];
            end
         end
         s = flip ? -y : y;
         c = flip ? -x : x;
      endfunction

      function longint heading_deg(input longint yin, input longint xin);
         longint x, y, z, t, xs, ys, d;
         x = xin;
         y = yin;
         z = 0;
         if (x == 0 && y == 0) return 0;
         // left half plane: turn the vector round and start from plus or minus pi
         if (x < 0) begin
            z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
            x = -x;
            y = -y;
         end
         for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0) begin
               t = x - ys; y = y + xs; x = t; z -= ARCTAN_Q30[i];
            end else begin
               t = x + ys; y = y - xs; x = t; z += ARCTAN_Q30[i];
            end
         end
         d = (z * 64'sd3754936 + (64'sd1 <<< 29)) >>> 30;
         if (d > (64'sd180 <<< 16)) d = 64'sd180 <<< 16;
         if (d < -(64'sd180 <<< 16)) d = -(64'sd180 <<< 16);
         return d;
      endfunction

      // note an accepted report and queue its bearing if it passes the gate
      function void note_report(input logic [ADDR_W-1:0] addr, input longint lat,
                                input longint lon);
         longint s_lat, c_lat, s_ref, c_ref, s_dl, c_dl, y, x;
         bearing_result_type r;
         if (lat >= ref_lat + WIN_HALF || lon >= ref_lon + WIN_HALF ||
             lat < ref_lat - WIN_HALF || lon < ref_lon - WIN_HALF) begin
            dropped++;
            return;
         end
         sine_cosine(lat, s_lat, c_lat);
         sine_cosine(ref_lat, s_ref, c_ref);
         sine_cosine(lon - ref_lon, s_dl, c_dl);
         y = (s_dl * c_lat) >>> 30;
         x = ((c_ref * s_lat) >>> 30) - ((((s_ref * c_lat) >>> 30) * c_dl) >>> 30);
         r.address = addr;
         r.bearing = BEAR_W'(heading_deg(y, x));
         awaited = {awaited, r};
      endfunction

      // compare one bearing transfer with the oldest expectation
      function void check_bearing(input logic [ADDR_W-1:0] addr,
                                  input logic signed [BEAR_W-1:0] bearing);
         bearing_result_type e;
         if (awaited.size() == 0) begin
            $error("unexpected bearing transfer: address %h bearing %0d", addr, bearing);
            failures++;
            return;
         end
         e = awaited.pop_front();
         matched++;
         if (addr !== e.address) begin
            $error("result_address mismatch: expected %h, actual %h", e.address, addr);
            failures++;
         end
         if (bearing !== e.bearing) begin
            $error("bearing mismatch: expected %0d, actual %0d", e.bearing, bearing);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;
   bit   steady_source;
   bit   steady_sink;
   int   settings_used;

   gcb_req_if req_chan ();
   gcb_rsp_if rsp_chan ();

   bearing_scoreboard sb = new();

   gated_great_circle_bearing dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // watch both channels for transfers
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         sb.note_report(req_chan.aircraft_address, longint'(req_chan.latitude),
                        longint'(req_chan.longitude));
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_bearing(rsp_chan.result_address, rsp_chan.bearing);
   end

   // result side: random stalls, with calm stretches
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         gap = steady_sink ? 0 : $urandom_range(0, 18);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   // register write: setup then access
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input longint value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // move the reference point once the pipeline has drained
   task automatic set_reference(input longint lat, input longint lon);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (PIPE_WAIT) @(posedge clock);
      write_reg(LAT_REG_ADDR, lat);
      write_reg(LON_REG_ADDR, lon);
      sb.ref_lat = longint'(LAT_W'(lat));
      sb.ref_lon = longint'(LON_W'(lon));
      settings_used++;
   endtask

   // one report transfer, with an optional random gap ahead of it
   task automatic send_report(input logic [ADDR_W-1:0] addr, input longint lat,
                              input longint lon, input bit no_gap);
      int gap;
      gap = (no_gap || steady_source) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.aircraft_address <= addr;
      req_chan.latitude         <= LAT_W'(lat);
      req_chan.longitude        <= LON_W'(lon);
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
   endtask

   // offset within the window, edges now and then
   function automatic longint window_offset();
      case ($urandom_range(0, 9))
         0: return -WIN_HALF;
         1: return WIN_HALF - 1;
         2: return 0;
         default: return longint'($urandom_range(0, 32'(4 * ONE_DEG - 1))) - WIN_HALF;
      endcase
   endfunction

   // mostly reports inside the window, the rest near misses and noise
   task automatic random_reports(input int count);
      longint lat, lon;
      int     kind;
      for (int n = 0; n < count; n++) begin
         if (n % 120 == 0) steady_source = ($urandom_range(0, 3) == 0);
         if (n % 150 == 0) steady_sink = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 19);
         lat  = sb.ref_lat + window_offset();
         lon  = sb.ref_lon + window_offset();
         if (kind == 0) lat = sb.ref_lat + WIN_HALF;
         else if (kind == 1) lon = sb.ref_lon - WIN_HALF - 1;
         else if (kind == 2) lon = sb.ref_lon + WIN_HALF + $urandom_range(0, 1000);
         else if (kind == 3) begin
            lat = longint'($signed(LAT_W'($urandom)));
            lon = longint'($signed(LON_W'($urandom)));
         end
         send_report(ADDR_W'($urandom), lat, lon, 1'b0);
      end
      steady_source = 0;
      steady_sink   = 0;
   endtask

   // stimulus
   initial begin
      settings_used             = 0;
      steady_source             = 0;
      steady_sink               = 0;
      reset                     = 1'b1;
      csr_psel                  = 1'b0;
      csr_penable               = 1'b0;
      csr_pwrite                = 1'b0;
      csr_paddr                 = '0;
      csr_pwdata                = '0;
      req_chan.valid            = 1'b0;
      req_chan.aircraft_address = '0;
      req_chan.latitude         = '0;
      req_chan.longitude        = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: window edges, zero vector, field extremes around the origin
      send_report(24'h000000, 0, 0, 1'b1);
      send_report(24'hFFFFFF, -WIN_HALF, -WIN_HALF, 1'b1);
      send_report(24'h5A5A5A, WIN_HALF - 1, WIN_HALF - 1, 1'b0);
      send_report(24'hA5A5A5, WIN_HALF, 0, 1'b1);
      send_report(24'h123456, 0, WIN_HALF, 1'b0);
      send_report(24'h654321, -WIN_HALF - 1, 0, 1'b0);
      send_report(24'h0F0F0F, 0, -WIN_HALF - 1, 1'b1);
      send_report(24'h111111, LAT_MAX, LON_MAX, 1'b0);
      send_report(24'h222222, -LAT_MAX, -LON_MAX, 1'b0);
      send_report(24'h333333, (64'sd1 << (LAT_W - 1)) - 1, (64'sd1 << (LON_W - 1)) - 1, 1'b0);
      send_report(24'h444444, -(64'sd1 << (LAT_W - 1)), -(64'sd1 << (LON_W - 1)), 1'b1);
      send_report(24'h555555, WIN_HALF - 1, -WIN_HALF, 1'b0);
      send_report(24'h666666, -WIN_HALF, WIN_HALF - 1, 1'b0);
      send_report(24'h777777, ONE_DEG, 0, 1'b0);
      send_report(24'h888888, 0, ONE_DEG, 1'b0);

      // directed at the pole and the date line: window runs past 90 degrees
      set_reference(LAT_MAX, LON_MAX);
      send_report(24'h999999, LAT_MAX + WIN_HALF - 1, LON_MAX + WIN_HALF - 1, 1'b1);
      send_report(24'hAAAAAA, LAT_MAX - WIN_HALF, LON_MAX - WIN_HALF, 1'b0);
      send_report(24'hBBBBBB, LAT_MAX, LON_MAX, 1'b0);
      send_report(24'hCCCCCC, LAT_MAX, -LON_MAX, 1'b0);
      random_reports(240);

      set_reference(-LAT_MAX, -LON_MAX);
      send_report(24'hDDDDDD, -LAT_MAX - WIN_HALF, -LON_MAX - WIN_HALF, 1'b0);
      send_report(24'hEEEEEE, -LAT_MAX, -LON_MAX, 1'b0);
      random_reports(240);

      set_reference(0, 0);
      random_reports(240);

      set_reference(longint'($urandom_range(0, 32'(2 * LAT_MAX))) - LAT_MAX,
                    longint'($urandom_range(0, 32'(2 * LON_MAX))) - LON_MAX);
      random_reports(240);

      set_reference(LAT_MAX / 2 + 12345, -(LON_MAX * 2) / 3);
      random_reports(240);

      set_reference(-LAT_MAX + WIN_HALF / 3, LON_MAX - 7);
      random_reports(240);

      // drain
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (PIPE_WAIT) @(posedge clock);

      $display("%0d bearings checked, %0d reports dropped by the gate, %0d reference points",
               sb.matched, sb.dropped, settings_used);
      if (sb.failures == 0 && sb.awaited.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("timeout with %0d bearings outstanding", sb.awaited.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
